@@ rtl/sud_pkg.sv @@
// ----------------------------------------------------------------------------
// sud_pkg
// Shared widths, operation codes and pipeline types for the divider.
// ----------------------------------------------------------------------------
package sud_pkg;

    localparam int DATA_WIDTH = 64;
    localparam int OP_WIDTH   = 2;

    localparam logic [OP_WIDTH-1:0] OP_DIVU = 2'd0;
    localparam logic [OP_WIDTH-1:0] OP_DIVS = 2'd1;
    localparam logic [OP_WIDTH-1:0] OP_REMU = 2'd2;
    localparam logic [OP_WIDTH-1:0] OP_REMS = 2'd3;

    // Partial remainder, dividend/quotient shift word, divisor magnitude.
    typedef struct packed {
        logic [DATA_WIDTH-1:0] rem;
        logic [DATA_WIDTH-1:0] numq;
        logic [DATA_WIDTH-1:0] den;
    } stage_data_t;

    // Per-request control carried alongside the data.
    typedef struct packed {
        logic want_rem;
        logic neg_res;
        logic zero;
    } stage_ctl_t;

endpackage

@@ rtl/sud_prep.sv @@
// ----------------------------------------------------------------------------
// sud_prep
// Entry stage: decodes the operation, takes operand magnitudes and
// works out the sign of the result.
// ----------------------------------------------------------------------------
module sud_prep
    import sud_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  valid_in,
    input  logic [OP_WIDTH-1:0]   op,
    input  logic [DATA_WIDTH-1:0] dividend,
    input  logic [DATA_WIDTH-1:0] divisor,
    output logic                  valid_out,
    output stage_data_t           data_out,
    output stage_ctl_t            ctl_out
);

    logic        valid_reg;
    logic        valid_next;
    stage_data_t data_reg;
    stage_data_t data_next;
    stage_ctl_t  ctl_reg;
    stage_ctl_t  ctl_next;

    logic                  is_signed;
    logic                  want_rem;
    logic                  a_neg;
    logic                  b_neg;
    logic [DATA_WIDTH-1:0] a_mag;
    logic [DATA_WIDTH-1:0] b_mag;

    always_comb
    begin
        case (op)
            OP_DIVU:
            begin
                is_signed = 1'b0;
                want_rem  = 1'b0;
            end
            OP_DIVS:
            begin
                is_signed = 1'b1;
                want_rem  = 1'b0;
            end
            OP_REMU:
            begin
                is_signed = 1'b0;
                want_rem  = 1'b1;
            end
            OP_REMS:
            begin
                is_signed = 1'b1;
                want_rem  = 1'b1;
            end
            default:
            begin
                is_signed = 1'b0;
                want_rem  = 1'b0;
            end
        endcase

        a_neg = is_signed & dividend[DATA_WIDTH-1];
        b_neg = is_signed & divisor[DATA_WIDTH-1];
        a_mag = a_neg ? (~dividend + 1'b1) : dividend;
        b_mag = b_neg ? (~divisor + 1'b1) : divisor;

        data_next.rem  = '0;
        data_next.numq = a_mag;
        data_next.den  = b_mag;

        ctl_next.want_rem = want_rem;
        ctl_next.neg_res  = want_rem ? a_neg : (a_neg ^ b_neg);
        ctl_next.zero     = (divisor == '0);

        valid_next = en ? valid_in : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
            ctl_reg  <= ctl_next;
        end
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;
    assign ctl_out   = ctl_reg;

endmodule

@@ rtl/sud_step.sv @@
// ----------------------------------------------------------------------------
// sud_step
// One restoring division stage: one trial subtract, one quotient bit.
// ----------------------------------------------------------------------------
module sud_step
    import sud_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        valid_in,
    input  stage_data_t data_in,
    input  stage_ctl_t  ctl_in,
    output logic        valid_out,
    output stage_data_t data_out,
    output stage_ctl_t  ctl_out
);

    logic        valid_reg;
    logic        valid_next;
    stage_data_t data_reg;
    stage_data_t data_next;
    stage_ctl_t  ctl_reg;

    logic [DATA_WIDTH:0] part;
    logic [DATA_WIDTH:0] diff;
    logic                q_bit;

    always_comb
    begin
        part  = {data_in.rem, data_in.numq[DATA_WIDTH-1]};
        diff  = part - {1'b0, data_in.den};
        q_bit = ~diff[DATA_WIDTH];

        data_next.rem  = q_bit ? diff[DATA_WIDTH-1:0] : part[DATA_WIDTH-1:0];
        data_next.numq = {data_in.numq[DATA_WIDTH-2:0], q_bit};
        data_next.den  = data_in.den;

        valid_next = en ? valid_in : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
            ctl_reg  <= ctl_in;
        end
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;
    assign ctl_out   = ctl_reg;

endmodule

@@ rtl/sud_post.sv @@
// ----------------------------------------------------------------------------
// sud_post
// Result selection, sign fix-up and zero-divisor override, followed by an
// output register with a skid entry that drives the pipeline enable.
// ----------------------------------------------------------------------------
module sud_post
    import sud_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  valid_in,
    input  stage_data_t           data_in,
    input  stage_ctl_t            ctl_in,
    output logic                  en,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output logic [DATA_WIDTH-1:0] result
);

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [DATA_WIDTH-1:0] out_data_reg;
    logic [DATA_WIDTH-1:0] out_data_next;
    logic                  skid_valid_reg;
    logic                  skid_valid_next;
    logic [DATA_WIDTH-1:0] skid_data_reg;
    logic [DATA_WIDTH-1:0] skid_data_next;

    logic [DATA_WIDTH-1:0] sel;
    logic [DATA_WIDTH-1:0] res;

    always_comb
    begin
        sel = ctl_in.want_rem ? data_in.rem : data_in.numq;
        if (ctl_in.zero)
        begin
            res = '0;
        end
        else if (ctl_in.neg_res)
        begin
            res = ~sel + 1'b1;
        end
        else
        begin
            res = sel;
        end
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;

        if (skid_valid_reg)
        begin
            // pipeline frozen; drain the skid entry
            if (rsp_ready)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (!out_valid_reg || rsp_ready)
        begin
            out_valid_next = valid_in;
            if (valid_in)
            begin
                out_data_next = res;
            end
        end
        else if (valid_in)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign en        = ~skid_valid_reg;
    assign rsp_valid = out_valid_reg;
    assign result    = out_data_reg;

endmodule

@@ rtl/signed_unsigned_divider_64.sv @@
// ----------------------------------------------------------------------------
// signed_unsigned_divider_64
// Pipelined signed/unsigned 64-bit divide and remainder.
// ----------------------------------------------------------------------------
// Takes one request per cycle while req_ready is high and returns one result
// per request, in order. The path from request to result runs through one entry
// stage (operand magnitudes), 64 restoring stages (one quotient bit each, one
// 65-bit trial subtract per stage) and one output register. A skid entry behind
// the output register absorbs one result when rsp_ready drops; req_ready falls
// only while that entry is occupied.
// Division by zero returns 0 in every mode; the most negative dividend over
// -1 returns the most negative value as quotient and 0 as remainder.
// ----------------------------------------------------------------------------
module signed_unsigned_divider_64
    import sud_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  logic [OP_WIDTH-1:0]   op,
    input  logic [DATA_WIDTH-1:0] dividend,
    input  logic [DATA_WIDTH-1:0] divisor,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output logic [DATA_WIDTH-1:0] result
);

    logic        en;
    logic        stg_valid [DATA_WIDTH+1];
    stage_data_t stg_data  [DATA_WIDTH+1];
    stage_ctl_t  stg_ctl   [DATA_WIDTH+1];

    assign req_ready = en;

    sud_prep u_prep
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (req_valid),
        .op        (op),
        .dividend  (dividend),
        .divisor   (divisor),
        .valid_out (stg_valid[0]),
        .data_out  (stg_data[0]),
        .ctl_out   (stg_ctl[0])
    );

    for (genvar i = 0; i < DATA_WIDTH; i++)
    begin : g_step
        sud_step u_step
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .valid_in  (stg_valid[i]),
            .data_in   (stg_data[i]),
            .ctl_in    (stg_ctl[i]),
            .valid_out (stg_valid[i+1]),
            .data_out  (stg_data[i+1]),
            .ctl_out   (stg_ctl[i+1])
        );
    end

    sud_post u_post
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (stg_valid[DATA_WIDTH]),
        .data_in   (stg_data[DATA_WIDTH]),
        .ctl_in    (stg_ctl[DATA_WIDTH]),
        .en        (en),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .result    (result)
    );

endmodule

@@ bench/tb_signed_unsigned_divider_64.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_signed_unsigned_divider_64
// Self-checking bench for the pipelined signed/unsigned divider.
// ----------------------------------------------------------------------------
// A short directed set covers zero divisors, the most negative dividend over
// -1, all-ones operands and mixed signs for each operation, followed by
// random requests with random idling on both sides. Each accepted request is
// predicted on the spot and results are compared in order. One long output
// hold-off fills the pipeline so the request side stalls.
// ----------------------------------------------------------------------------
module tb_signed_unsigned_divider_64;

    import sud_pkg::*;

    localparam logic [DATA_WIDTH-1:0] MOST_NEG = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam logic [DATA_WIDTH-1:0] MOST_POS = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] ALL_ONES = {DATA_WIDTH{1'b1}};
    localparam int RANDOM_REQUESTS = 1426;
    localparam int MAX_IDLE        = 18;
    localparam int HOLD_OFF_AT     = 300;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_CYCLES    = 80;
    localparam int WATCHDOG_LIMIT  = 2000;

    typedef struct {
        logic [OP_WIDTH-1:0]   op;
        logic [DATA_WIDTH-1:0] dividend;
        logic [DATA_WIDTH-1:0] divisor;
        int unsigned           gap;
    } division_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  req_valid = 1'b0;
    logic                  req_ready;
    logic [OP_WIDTH-1:0]   op        = OP_DIVU;
    logic [DATA_WIDTH-1:0] dividend  = '0;
    logic [DATA_WIDTH-1:0] divisor   = '0;
    logic                  rsp_valid;
    logic                  rsp_ready = 1'b0;
    logic [DATA_WIDTH-1:0] result;

    division_t             queued_divisions[$];
    logic [DATA_WIDTH-1:0] awaited_results[$];

    logic        req_taken     = 1'b0;
    logic        rsp_taken     = 1'b0;
    int unsigned req_idle      = 0;
    int unsigned rsp_idle      = 0;
    int unsigned results_seen  = 0;
    int unsigned quiet_cycles  = 0;
    int unsigned mismatches    = 0;
    int unsigned hold          = 0;
    division_t   next_division;
    logic [DATA_WIDTH-1:0] want;

    signed_unsigned_divider_64 dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .op        (op),
        .dividend  (dividend),
        .divisor   (divisor),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .result    (result)
    );

    always #6 clk = ~clk;

    function automatic logic [DATA_WIDTH-1:0] quotient_or_remainder(
        logic [OP_WIDTH-1:0] code, logic [DATA_WIDTH-1:0] a, logic [DATA_WIDTH-1:0] b);
        logic [DATA_WIDTH-1:0] mag_a;
        logic [DATA_WIDTH-1:0] mag_b;
        logic [DATA_WIDTH-1:0] quo;
        logic [DATA_WIDTH-1:0] rem;
        if (b == '0)
            return '0;
        case (code)
            OP_DIVU: return a / b;
            OP_REMU: return a % b;
            default:
            begin
                mag_a = a[DATA_WIDTH-1] ? -a : a;
                mag_b = b[DATA_WIDTH-1] ? -b : b;
                quo   = mag_a / mag_b;
                rem   = mag_a % mag_b;
                if (code == OP_REMS)
                    return a[DATA_WIDTH-1] ? -rem : rem;
                return (a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1]) ? -quo : quo;
            end
        endcase
    endfunction

    // stretches with no idling on either side
    function automatic bit busy_stretch(int unsigned n);
        return (n >= 250 && n < 650) || (n >= 700 && n < 850) || (n >= 1200 && n < 1260);
    endfunction

    function automatic int unsigned idle_draw(int unsigned n);
        return busy_stretch(n) ? 0 : $urandom_range(0, MAX_IDLE);
    endfunction

    function automatic logic [DATA_WIDTH-1:0] random_operand();
        logic [DATA_WIDTH-1:0] full;
        full = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: return full;
            1: return DATA_WIDTH'($urandom_range(0, 15));
            2:
            begin
                case ($urandom_range(0, 4))
                    0: return '0;
                    1: return DATA_WIDTH'(1);
                    2: return ALL_ONES;
                    3: return MOST_NEG;
                    default: return MOST_POS;
                endcase
            end
            3: return full >> $urandom_range(1, DATA_WIDTH - 1);
            4: return -DATA_WIDTH'($urandom_range(1, 15));
            default: return {{32{full[63]}}, full[31:0]};
        endcase
    endfunction

    // request driver
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
        end
        else if (req_valid && !req_taken)
        begin
        end
        else if (req_idle != 0)
        begin
            req_valid <= 1'b0;
            req_idle  <= req_idle - 1;
        end
        else if (queued_divisions.size() != 0)
        begin
            next_division = queued_divisions.pop_front();
            op        <= next_division.op;
            dividend  <= next_division.dividend;
            divisor   <= next_division.divisor;
            req_idle  <= next_division.gap;
            req_valid <= 1'b1;
        end
        else
        begin
            req_valid <= 1'b0;
        end
    end

    // result receiver
    always @(negedge clk)
    begin
        if (rsp_taken)
        begin
            hold = (results_seen == HOLD_OFF_AT) ? HOLD_OFF_CYCLES : idle_draw(results_seen);
            rsp_ready <= (hold == 0);
            rsp_idle  <= (hold == 0) ? 0 : hold - 1;
        end
        else if (!rsp_ready)
        begin
            if (rsp_idle == 0)
                rsp_ready <= 1'b1;
            else
                rsp_idle <= rsp_idle - 1;
        end
    end

    // monitor, checker and watchdog
    always @(posedge clk)
    begin
        req_taken <= rst_n && req_valid && req_ready;
        rsp_taken <= rst_n && rsp_valid && rsp_ready;
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
            begin
                results_seen <= results_seen + 1;
                if (awaited_results.size() == 0)
                begin
                    mismatches++;
                    $error("result: no request outstanding, actual %h", result);
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (result !== want)
                    begin
                        mismatches++;
                        $error("result mismatch: expected %h, actual %h", want, result);
                    end
                end
            end
            if (req_valid && req_ready)
                awaited_results.push_back(quotient_or_remainder(op, dividend, divisor));
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial
    begin
        logic [DATA_WIDTH-1:0] pair_a [6];
        logic [DATA_WIDTH-1:0] pair_b [6];
        division_t             d;
        int unsigned           n;

        pair_a = '{64'd123, MOST_NEG, ALL_ONES, -64'd7, 64'd7, 64'd0};
        pair_b = '{64'd0, ALL_ONES, 64'd1, 64'd2, -64'd2, MOST_NEG};
        n = 0;
        for (int k = 0; k < 4; k++)
        begin
            for (int j = 0; j < 6; j++)
            begin
                d.op       = OP_WIDTH'(k);
                d.dividend = pair_a[j];
                d.divisor  = pair_b[j];
                d.gap      = idle_draw(n);
                queued_divisions.push_back(d);
                n++;
            end
        end
        for (int i = 0; i < RANDOM_REQUESTS; i++)
        begin
            d.op       = OP_WIDTH'($urandom_range(0, 3));
            d.dividend = random_operand();
            d.divisor  = random_operand();
            d.gap      = idle_draw(n);
            queued_divisions.push_back(d);
            n++;
        end

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (queued_divisions.size() != 0 || req_valid || awaited_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatches == 0 && awaited_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
